/* hdl/m3i_pkg.sv */
// Shared constants and helpers for the 3x3 matrix inverse core.
// No dependencies; every other file of the block imports this package.
package m3i_pkg;

    localparam int ELEM_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int DIM        = 3;
    localparam int NELEM      = DIM * DIM;
    localparam int QDEPTH     = 4;

    // Row or column index that remains after striking index idx; sel picks the
    // lower (0) or upper (1) of the two that remain.
    function automatic int other_idx(input int idx, input int sel);
        int res;
        if (sel == 0) begin
            res = (idx == 0) ? 1 : 0;
        end else begin
            res = (idx == 2) ? 1 : 2;
        end
        return res;
    endfunction

endpackage

/* hdl/m3i_front.sv */
// Front end: accepts matrices, forms the nine cofactors and the determinant.
// Depends on m3i_pkg.
module m3i_front import m3i_pkg::*; #(
    parameter int EW = ELEM_WIDTH,
    localparam int CW = 2 * EW + 1,
    localparam int DW = 3 * EW + 3
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [NELEM*EW-1:0]     i_m,
    output logic                    o_push,
    input  logic                    i_full,
    output logic [NELEM*CW+DW-1:0]  o_data
);

    localparam int PW = 2 * EW;

    logic signed [EW-1:0] w_m [NELEM];
    logic [3:0]           r_v;
    logic                 en;

    logic signed [PW-1:0]   r_pt  [NELEM];
    logic signed [PW-1:0]   r_pu  [NELEM];
    logic signed [CW-1:0]   r_c2  [NELEM];
    logic signed [CW-1:0]   r_c3  [NELEM];
    logic signed [CW-1:0]   r_c4  [NELEM];
    logic signed [EW-1:0]   r_m0a [DIM];
    logic signed [EW-1:0]   r_m0b [DIM];
    logic signed [PW+1:0]   r_plo [DIM];
    logic signed [PW-1:0]   r_phi [DIM];
    logic signed [DW-1:0]   r_det;
    logic signed [DW-1:0]   n_det;

    always_comb begin
        for (int e = 0; e < NELEM; e++) begin
            w_m[e] = i_m[e*EW +: EW];
        end
    end

    assign en      = !r_v[3] || !i_full;
    assign o_stall = !en;
    assign o_push  = r_v[3] && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    genvar gi, gj;
    generate
        for (gi = 0; gi < DIM; gi++) begin : g_row
            for (gj = 0; gj < DIM; gj++) begin : g_col
                localparam int R0 = other_idx(gi, 0);
                localparam int R1 = other_idx(gi, 1);
                localparam int C0 = other_idx(gj, 0);
                localparam int C1 = other_idx(gj, 1);
                localparam int E  = gi * DIM + gj;
                always_ff @(posedge i_clk) begin
                    if (en) begin
                        r_pt[E] <= w_m[R0*DIM+C0] * w_m[R1*DIM+C1];
                        r_pu[E] <= w_m[R0*DIM+C1] * w_m[R1*DIM+C0];
                        if (((gi + gj) % 2) == 1) begin
                            r_c2[E] <= $signed({r_pu[E][PW-1], r_pu[E]})
                                     - $signed({r_pt[E][PW-1], r_pt[E]});
                        end else begin
                            r_c2[E] <= $signed({r_pt[E][PW-1], r_pt[E]})
                                     - $signed({r_pu[E][PW-1], r_pu[E]});
                        end
                        r_c3[E] <= r_c2[E];
                        r_c4[E] <= r_c3[E];
                    end
                end
            end
        end
    endgenerate

    // The 65-bit cofactor is split so each multiplier operand stays near one word wide.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < DIM; j++) begin
                r_m0a[j] <= w_m[j];
                r_m0b[j] <= r_m0a[j];
                r_plo[j] <= r_m0b[j] * $signed({1'b0, r_c2[j][EW:0]});
                r_phi[j] <= r_m0b[j] * $signed(r_c2[j][CW-1:EW+1]);
            end
            r_det <= n_det;
        end
    end

    always_comb begin
        n_det = '0;
        for (int j = 0; j < DIM; j++) begin
            n_det = n_det
                  + ($signed({{(DW-PW){r_phi[j][PW-1]}}, r_phi[j]}) <<< (EW + 1))
                  + $signed({{(DW-PW-2){r_plo[j][PW+1]}}, r_plo[j]});
        end
    end

    always_comb begin
        for (int e = 0; e < NELEM; e++) begin
            o_data[e*CW +: CW] = r_c4[e];
        end
        o_data[NELEM*CW +: DW] = r_det;
    end

endmodule

/* hdl/m3i_fifo.sv */
// Short register queue between the front end and the divider back end.
// Depends on m3i_pkg.
module m3i_fifo import m3i_pkg::*; #(
    parameter int W     = 8,
    parameter int DEPTH = QDEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [W-1:0]    r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [CNTW-1:0] r_cnt;

    assign o_full  = (r_cnt == CNTW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

/* hdl/m3i_back.sv */
// Back end: scales the adjugate by the determinant through pipelined long
// division with rounding and saturation. Depends on m3i_pkg.
module m3i_back import m3i_pkg::*; #(
    parameter int EW = ELEM_WIDTH,
    parameter int FB = FRAC_BITS,
    localparam int CW = 2 * EW + 1,
    localparam int DW = 3 * EW + 3
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [NELEM*CW+DW-1:0]  i_data,
    input  logic                    i_empty,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [NELEM*EW-1:0]     o_r,
    output logic                    o_singular,
    output logic                    o_saturated
);

    localparam int QB  = EW + 1;
    localparam int NS  = QB + 1;
    localparam int NMW = CW + 2 * FB + 1;
    localparam int NW  = ((NMW > DW) ? NMW : DW) + 1;
    localparam int WW  = ((NW > DW + 1 + QB) ? NW : DW + 1 + QB) + 1;

    logic                 en;
    logic [NS:0]          r_vb;
    logic                 r_ov;

    logic [WW-1:0]        r_rem  [NS+1][NELEM];
    logic [QB-1:0]        r_q    [NS+1][NELEM];
    logic                 r_ovf  [NS+1][NELEM];
    logic                 r_neg  [NS+1][NELEM];
    logic [DW:0]          r_d    [NS+1];
    logic                 r_sing [NS+1];

    logic signed [DW-1:0] w_det;
    logic [DW-1:0]        w_dabs;
    logic [NELEM-1:0]     w_over;
    logic [EW-1:0]        w_val  [NELEM];
    logic [EW-1:0]        r_out  [NELEM];
    logic                 r_sat;
    logic                 r_sg;

    assign en    = !(r_ov && i_stall);
    assign o_pop = !i_empty && en;

    assign w_det  = i_data[NELEM*CW +: DW];
    assign w_dabs = w_det[DW-1] ? (~w_det + 1'b1) : w_det;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_vb <= {r_vb[NS-1:0], o_pop};
            r_ov <= r_vb[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d[0]    <= {w_dabs, 1'b0};
            r_sing[0] <= (w_det == '0);
        end
    end

    genvar ge, gs;
    generate
        for (ge = 0; ge < NELEM; ge++) begin : g_elem
            // Result row i, column j comes from cofactor row j, column i.
            localparam int CI = (ge % DIM) * DIM + (ge / DIM);
            logic signed [CW-1:0] w_c;
            logic [CW-1:0]        w_cabs;
            assign w_c    = i_data[CI*CW +: CW];
            assign w_cabs = w_c[CW-1] ? (~w_c + 1'b1) : w_c;

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_rem[0][ge] <= (WW'(w_cabs) << (2 * FB + 1)) + WW'(w_dabs);
                    r_neg[0][ge] <= w_c[CW-1] ^ w_det[DW-1];
                    r_q[0][ge]   <= '0;
                    r_ovf[0][ge] <= 1'b0;
                end
            end

            // The first step only detects a quotient too large for QB bits.
            for (gs = 1; gs <= NS; gs++) begin : g_step
                localparam int K = QB - gs + 1;
                logic [WW-1:0] w_dk;
                logic          w_ge;
                assign w_dk = WW'(r_d[gs-1]) << K;
                assign w_ge = (r_rem[gs-1][ge] >= w_dk);
                always_ff @(posedge i_clk) begin
                    if (en) begin
                        r_rem[gs][ge] <= w_ge ? (r_rem[gs-1][ge] - w_dk) : r_rem[gs-1][ge];
                        r_neg[gs][ge] <= r_neg[gs-1][ge];
                        if (gs == 1) begin
                            r_ovf[gs][ge] <= w_ge;
                            r_q[gs][ge]   <= r_q[gs-1][ge];
                        end else begin
                            r_ovf[gs][ge] <= r_ovf[gs-1][ge];
                            r_q[gs][ge]   <= r_q[gs-1][ge] | (QB'(w_ge) << K);
                        end
                    end
                end
            end

            localparam logic [QB-1:0] LIM = QB'(1) << (EW - 1);
            always_comb begin
                w_over[ge] = r_ovf[NS][ge]
                          || (r_neg[NS][ge] ? (r_q[NS][ge] > LIM) : (r_q[NS][ge] >= LIM));
                if (w_over[ge]) begin
                    w_val[ge] = r_neg[NS][ge] ? {1'b1, {(EW-1){1'b0}}}
                                              : {1'b0, {(EW-1){1'b1}}};
                end else begin
                    w_val[ge] = r_neg[NS][ge] ? (~r_q[NS][ge][EW-1:0] + 1'b1)
                                              : r_q[NS][ge][EW-1:0];
                end
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_out[ge] <= r_sing[NS] ? '0 : w_val[ge];
                end
            end
            assign o_r[ge*EW +: EW] = r_out[ge];
        end

        for (gs = 1; gs <= NS; gs++) begin : g_ctl
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_d[gs]    <= r_d[gs-1];
                    r_sing[gs] <= r_sing[gs-1];
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sg  <= r_sing[NS];
            r_sat <= !r_sing[NS] && (|w_over);
        end
    end

    assign o_valid     = r_ov;
    assign o_singular  = r_sg;
    assign o_saturated = r_sat;

endmodule

/* hdl/matrix3_inverse_core.sv */
// Pipeline: four cofactor/determinant stages, one queue slot, ELEM_WIDTH + 3
// division stages and the output register. Throughput: one matrix per cycle
// while neither i_stall nor a full queue holds the flow, as the per-element
// divider is fully pipelined. Reset clears all valid bits and the queue
// pointers; data registers are not reset.
module matrix3_inverse_core import m3i_pkg::*; #(
    parameter int ELEM_WIDTH_P = ELEM_WIDTH,
    parameter int FRAC_BITS_P  = FRAC_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [ELEM_WIDTH_P-1:0] i_m00,
    input  logic [ELEM_WIDTH_P-1:0] i_m01,
    input  logic [ELEM_WIDTH_P-1:0] i_m02,
    input  logic [ELEM_WIDTH_P-1:0] i_m10,
    input  logic [ELEM_WIDTH_P-1:0] i_m11,
    input  logic [ELEM_WIDTH_P-1:0] i_m12,
    input  logic [ELEM_WIDTH_P-1:0] i_m20,
    input  logic [ELEM_WIDTH_P-1:0] i_m21,
    input  logic [ELEM_WIDTH_P-1:0] i_m22,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [ELEM_WIDTH_P-1:0] o_r00,
    output logic [ELEM_WIDTH_P-1:0] o_r01,
    output logic [ELEM_WIDTH_P-1:0] o_r02,
    output logic [ELEM_WIDTH_P-1:0] o_r10,
    output logic [ELEM_WIDTH_P-1:0] o_r11,
    output logic [ELEM_WIDTH_P-1:0] o_r12,
    output logic [ELEM_WIDTH_P-1:0] o_r20,
    output logic [ELEM_WIDTH_P-1:0] o_r21,
    output logic [ELEM_WIDTH_P-1:0] o_r22,
    output logic                    o_singular,
    output logic                    o_saturated
);

    localparam int EW = ELEM_WIDTH_P;
    localparam int FW = NELEM * (2 * EW + 1) + 3 * EW + 3;

    logic [NELEM*EW-1:0] w_m;
    logic [NELEM*EW-1:0] w_r;
    logic [FW-1:0]       w_fdata, w_qdata;
    logic                w_push, w_full, w_pop, w_empty;

    assign w_m = {i_m22, i_m21, i_m20, i_m12, i_m11, i_m10, i_m02, i_m01, i_m00};

    m3i_front #(.EW(EW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_m     (w_m),
        .o_push  (w_push),
        .i_full  (w_full),
        .o_data  (w_fdata)
    );

    m3i_fifo #(.W(FW), .DEPTH(QDEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_fdata),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_qdata),
        .o_empty (w_empty)
    );

    m3i_back #(.EW(EW), .FB(FRAC_BITS_P)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data      (w_qdata),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_r         (w_r),
        .o_singular  (o_singular),
        .o_saturated (o_saturated)
    );

    assign o_r00 = w_r[0*EW +: EW];
    assign o_r01 = w_r[1*EW +: EW];
    assign o_r02 = w_r[2*EW +: EW];
    assign o_r10 = w_r[3*EW +: EW];
    assign o_r11 = w_r[4*EW +: EW];
    assign o_r12 = w_r[5*EW +: EW];
    assign o_r20 = w_r[6*EW +: EW];
    assign o_r21 = w_r[7*EW +: EW];
    assign o_r22 = w_r[8*EW +: EW];

endmodule

/* hdl/m3i_checker.sv */
// Port-level checks for the 3x3 matrix inverse core, bound to the top level.
// Depends on m3i_pkg and matrix3_inverse_core.
module m3i_checker import m3i_pkg::*; #(
    parameter int EW = ELEM_WIDTH
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_stall,
    input logic [EW-1:0] i_m00, i_m01, i_m02, i_m10, i_m11, i_m12, i_m20, i_m21, i_m22,
    input logic          o_valid,
    input logic          i_stall,
    input logic [EW-1:0] o_r00, o_r01, o_r02, o_r10, o_r11, o_r12, o_r20, o_r21, o_r22,
    input logic          o_singular,
    input logic          o_saturated
);

    localparam logic [EW-1:0] MAXV = {1'b0, {(EW-1){1'b1}}};
    localparam logic [EW-1:0] MINV = {1'b1, {(EW-1){1'b0}}};

    logic w_any_zero_fail, w_any_lim;

    assign w_any_zero_fail = (|o_r00) || (|o_r01) || (|o_r02) || (|o_r10) || (|o_r11)
                          || (|o_r12) || (|o_r20) || (|o_r21) || (|o_r22);
    assign w_any_lim = (o_r00 == MAXV) || (o_r00 == MINV) || (o_r01 == MAXV)
                    || (o_r01 == MINV) || (o_r02 == MAXV) || (o_r02 == MINV)
                    || (o_r10 == MAXV) || (o_r10 == MINV) || (o_r11 == MAXV)
                    || (o_r11 == MINV) || (o_r12 == MAXV) || (o_r12 == MINV)
                    || (o_r20 == MAXV) || (o_r20 == MINV) || (o_r21 == MAXV)
                    || (o_r21 == MINV) || (o_r22 == MAXV) || (o_r22 == MINV);

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> !w_any_zero_fail && !o_saturated)
        else $error("singular result with nonzero elements or saturation");

    a_sat_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> w_any_lim)
        else $error("saturation flagged but no element at a limit");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_r00) && $stable(o_r11)
                               && $stable(o_r22) && $stable(o_singular))
        else $error("stalled result changed");

endmodule

bind matrix3_inverse_core m3i_checker #(.EW(ELEM_WIDTH_P)) u_m3i_checker (.*);
